[rtl/ofb_pkg.sv]
// Shared types, constants and functions of the obfuscated frame builder.
// Used by ofb_front, ofb_queue, ofb_back and obfuscated_frame_builder_unit.
// No dependencies.
package ofb_pkg;

    localparam int unsigned MAX_DATA    = 240;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [7:0]  SYNC0    = 8'hAB;
    localparam logic [7:0]  SYNC1    = 8'hCD;
    localparam logic [7:0]  TAIL0    = 8'hDC;
    localparam logic [7:0]  TAIL1    = 8'hBA;
    localparam logic [7:0]  HDR_OVH  = 8'd4;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_REJECT = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        last;
        logic [15:0] id;
        logic [7:0]  len;
        logic [7:0]  data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] k;
        case (idx)
            4'd0:    k = 8'h16;
            4'd1:    k = 8'h6C;
            4'd2:    k = 8'h14;
            4'd3:    k = 8'hE6;
            4'd4:    k = 8'h2E;
            4'd5:    k = 8'h91;
            4'd6:    k = 8'h0D;
            4'd7:    k = 8'h40;
            4'd8:    k = 8'h21;
            4'd9:    k = 8'h35;
            4'd10:   k = 8'hD5;
            4'd11:   k = 8'h40;
            4'd12:   k = 8'h13;
            4'd13:   k = 8'h03;
            4'd14:   k = 8'hE9;
            default: k = 8'h80;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/ofb_front.sv]
// Front end: accepts input items, tracks the open frame, and turns each item
// into a command for the back end (or drops it). Depends on ofb_pkg.
module ofb_front
    import ofb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [15:0] i_cmd_id,
    input  logic [7:0]  i_body_len,
    input  logic [7:0]  i_data_byte,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic       r_open, n_open;
    logic [7:0] r_left, n_left;
    logic       w_accept;

    assign o_in_ready = !i_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_open     = r_open;
        n_left     = r_left;
        o_push     = 1'b0;
        o_cmd.kind = CMD_START;
        o_cmd.last = 1'b0;
        o_cmd.id   = i_cmd_id;
        o_cmd.len  = i_body_len;
        o_cmd.data = i_data_byte;
        if (w_accept) begin
            if (i_operation == OP_START) begin
                o_push = 1'b1;
                if (i_body_len > 8'(MAX_DATA)) begin
                    o_cmd.kind = CMD_REJECT;
                    n_open     = 1'b0;
                    n_left     = '0;
                end else begin
                    n_open = (i_body_len != '0);
                    n_left = i_body_len;
                end
            end else if (r_open && r_left != '0) begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_DATA;
                o_cmd.last = (r_left == 8'd1);
                n_left     = r_left - 8'd1;
                n_open     = (r_left != 8'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

[rtl/ofb_queue.sv]
// Short command queue between the front and back ends.
// Depends on ofb_pkg.
module ofb_queue
    import ofb_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_cmd          = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/ofb_back.sv]
// Back end: walks each queued command one output byte per cycle unless stalled,
// keeps the running CRC and key position, and holds the output register. Depends on ofb_pkg.
module ofb_back
    import ofb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_rejected
);

    localparam logic [1:0] TRL_CRC_LO = 2'd0;
    localparam logic [1:0] TRL_CRC_HI = 2'd1;
    localparam logic [1:0] TRL_TAIL0  = 2'd2;
    localparam logic [1:0] TRL_TAIL1  = 2'd3;

    logic [3:0]  r_step, n_step;
    logic [15:0] r_crc, n_crc;
    logic [3:0]  r_key, n_key;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_frame_end;
    logic        r_rejected;

    logic        w_adv;
    logic        w_last;
    logic        w_inner;
    logic        w_trl;
    logic [1:0]  w_tix;
    logic [7:0]  w_plain;
    logic [7:0]  w_byte;
    logic        w_end;
    logic        w_rej;
    logic [8:0]  w_pay;

    assign w_adv = !i_q_status.empty && (!r_out_valid || i_out_ready);
    assign o_pop = w_adv && w_last;
    assign w_pay = {1'b0, i_cmd.len} + {1'b0, HDR_OVH};

    always_comb begin
        w_last  = 1'b0;
        w_inner = 1'b0;
        w_trl   = 1'b0;
        w_tix   = TRL_CRC_LO;
        w_plain = '0;
        w_byte  = '0;
        w_end   = 1'b0;
        w_rej   = 1'b0;
        case (i_cmd.kind)
            CMD_START: begin
                w_last = (i_cmd.len == '0) ? (r_step == 4'd11) : (r_step == 4'd7);
                if (r_step[3]) begin
                    w_trl = 1'b1;
                    w_tix = r_step[1:0];
                end else begin
                    case (r_step[2:0])
                        3'd0:    w_byte = SYNC0;
                        3'd1:    w_byte = SYNC1;
                        3'd2:    w_byte = w_pay[7:0];
                        3'd3:    w_byte = {7'd0, w_pay[8]};
                        3'd4: begin
                            w_inner = 1'b1;
                            w_plain = i_cmd.id[7:0];
                        end
                        3'd5: begin
                            w_inner = 1'b1;
                            w_plain = i_cmd.id[15:8];
                        end
                        3'd6: begin
                            w_inner = 1'b1;
                            w_plain = i_cmd.len;
                        end
                        default: begin
                            w_inner = 1'b1;
                            w_plain = '0;
                        end
                    endcase
                end
            end
            CMD_DATA: begin
                w_last = i_cmd.last ? (r_step == 4'd4) : (r_step == 4'd0);
                if (r_step == 4'd0) begin
                    w_inner = 1'b1;
                    w_plain = i_cmd.data;
                end else begin
                    w_trl = 1'b1;
                    w_tix = 2'(r_step - 4'd1);
                end
            end
            CMD_REJECT: begin
                w_last = 1'b1;
                w_end  = 1'b1;
                w_rej  = 1'b1;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
        if (w_inner) begin
            w_byte = w_plain ^ key_byte(r_key);
        end
        if (w_trl) begin
            case (w_tix)
                TRL_CRC_LO: w_byte = r_crc[7:0] ^ key_byte(r_key);
                TRL_CRC_HI: w_byte = r_crc[15:8] ^ key_byte(r_key);
                TRL_TAIL0:  w_byte = TAIL0;
                default: begin
                    w_byte = TAIL1;
                    w_end  = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_step = r_step;
        n_crc  = r_crc;
        n_key  = r_key;
        if (w_adv) begin
            n_step = w_last ? '0 : r_step + 4'd1;
            if (i_cmd.kind == CMD_START && r_step == 4'd0) begin
                n_crc = '0;
                n_key = '0;
            end else if (w_inner) begin
                n_crc = crc_update(r_crc, w_plain);
                n_key = r_key + 4'd1;
            end else if (w_trl && (w_tix == TRL_CRC_LO || w_tix == TRL_CRC_HI)) begin
                n_key = r_key + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_crc       <= '0;
            r_key       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_crc  <= n_crc;
            r_key  <= n_key;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte  <= w_byte;
            r_frame_end <= w_end;
            r_rejected  <= w_rej;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_frame_end;
    assign o_rejected  = r_rejected;

endmodule

[rtl/obfuscated_frame_builder_unit.sv]
// Top level of the obfuscated frame builder: front end, command queue, back end.
// Depends on ofb_pkg, ofb_front, ofb_queue and ofb_back.
//
// Takes one input item per cycle while the command queue has room. Every
// transfer out carries one byte; the back end emits one byte per cycle while
// it has a queued command and the output is taken: a start gives 8 bytes (12
// with a zero length), a data item 1 byte (5 on the last one, with CRC and
// trailer), a rejected start 1 byte, a dropped data item none. Sustained input
// rate is thus set by the single-byte output port; the QUEUE_DEPTH-entry queue
// absorbs header and trailer bursts.
module obfuscated_frame_builder_unit
    import ofb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [15:0] i_cmd_id,
    input  logic [7:0]  i_body_len,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic        o_rejected
);

    logic      w_push;
    logic      w_pop;
    t_cmd      w_cmd_in;
    t_cmd      w_cmd_head;
    t_q_status w_q_status;

    ofb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_cmd_id    (i_cmd_id),
        .i_body_len  (i_body_len),
        .i_data_byte (i_data_byte),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    ofb_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd_in),
        .i_pop    (w_pop),
        .o_cmd    (w_cmd_head),
        .o_status (w_q_status)
    );

    ofb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_rejected  (o_rejected)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("command popped from empty queue");

    a_reject_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> (o_frame_end && o_out_byte == 8'h00))
        else $error("rejection transfer malformed");

    a_pop_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid)
        else $error("command retired without output");

endmodule

[tb/sv/ofb_frame_checker.sv]
// Scoreboard for the obfuscated frame builder: predicts the framed byte stream
// from every input transfer and checks every output transfer against it.
// Depends on ofb_pkg.
module ofb_frame_checker
    import ofb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_operation,
    input  logic [15:0] i_cmd_id,
    input  logic [7:0]  i_body_len,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_frame_end,
    input  logic        i_rejected,
    output int          o_errors,
    output int          o_pending,
    output int          o_frames,
    output int          o_rejects,
    output int          o_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    // obfuscation key, entry 0 in the low byte
    localparam logic [127:0] KEY_STREAM = 128'h80E9_0313_40D5_3521_400D_912E_E614_6C16;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
        logic       rej;
    } t_wire_byte;

    t_wire_byte  wire_q[$];
    t_wire_byte  want;
    logic        frame_live;
    logic [7:0]  data_left;
    logic [3:0]  key_pos;
    logic [15:0] frame_crc;
    int          errors;
    int          frames;
    int          rejects;
    int          bytes;

    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last, input logic rej);
        wire_q.push_back({b, last, rej});
    endtask

    task automatic push_masked(input logic [7:0] b);
        push_byte(b ^ KEY_STREAM[{key_pos, 3'b000} +: 8], 1'b0, 1'b0);
        key_pos = key_pos + 4'd1;
    endtask

    task automatic push_inner(input logic [7:0] b);
        frame_crc = crc_fold(frame_crc, b);
        push_masked(b);
    endtask

    task automatic close_frame();
        push_masked(frame_crc[7:0]);
        push_masked(frame_crc[15:8]);
        push_byte(TAIL0, 1'b0, 1'b0);
        push_byte(TAIL1, 1'b1, 1'b0);
        frame_live = 1'b0;
        data_left  = '0;
        key_pos    = '0;
        frame_crc  = '0;
    endtask

    task automatic build_frame_bytes(input logic op, input logic [15:0] id,
                                     input logic [7:0] len, input logic [7:0] db);
        logic [15:0] pay;
        if (op == OP_START) begin
            frame_live = 1'b0;
            data_left  = '0;
            key_pos    = '0;
            frame_crc  = '0;
            if (len > MAX_DATA) begin
                push_byte(8'h00, 1'b1, 1'b1);
            end else begin
                pay = {8'h00, len} + {8'h00, HDR_OVH};
                push_byte(SYNC0, 1'b0, 1'b0);
                push_byte(SYNC1, 1'b0, 1'b0);
                push_byte(pay[7:0], 1'b0, 1'b0);
                push_byte(pay[15:8], 1'b0, 1'b0);
                push_inner(id[7:0]);
                push_inner(id[15:8]);
                push_inner(len);
                push_inner(8'h00);
                if (len == 8'd0) begin
                    close_frame();
                end else begin
                    frame_live = 1'b1;
                    data_left  = len;
                end
            end
        end else if (frame_live && data_left != 8'd0) begin
            push_inner(db);
            data_left = data_left - 8'd1;
            if (data_left == 8'd0) begin
                close_frame();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wire_q.delete();
            frame_live = 1'b0;
            data_left  = '0;
            key_pos    = '0;
            frame_crc  = '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                build_frame_bytes(i_operation, i_cmd_id, i_body_len, i_data_byte);
            end
            if (i_out_valid && i_out_ready) begin
                bytes++;
                if (wire_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer out, byte %02h end %0b rej %0b",
                             $realtime, i_out_byte, i_frame_end, i_rejected);
                end else begin
                    want = wire_q.pop_front();
                    if (want.last && !want.rej) frames++;
                    if (want.rej) rejects++;
                    if (i_out_byte !== want.val) begin
                        errors++;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $realtime, want.val, i_out_byte);
                    end
                    if (i_frame_end !== want.last) begin
                        errors++;
                        $display("%0t: frame_end expected %0b, got %0b",
                                 $realtime, want.last, i_frame_end);
                    end
                    if (i_rejected !== want.rej) begin
                        errors++;
                        $display("%0t: rejected expected %0b, got %0b",
                                 $realtime, want.rej, i_rejected);
                    end
                end
            end
        end
        o_pending <= wire_q.size();
        o_errors  <= errors;
        o_frames  <= frames;
        o_rejects <= rejects;
        o_bytes   <= bytes;
    end

endmodule

[tb/sv/obfuscated_frame_builder_unit_tb.sv]
// Testbench top for obfuscated_frame_builder_unit: clock, reset, input and
// output handshake stimulus with random stalls, and the final verdict.
// Depends on ofb_pkg, obfuscated_frame_builder_unit and ofb_frame_checker.
module obfuscated_frame_builder_unit_tb
    import ofb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_LEN     = 40;
    localparam int CUT_LEN      = 20;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        operation   = OP_START;
    logic [15:0] cmd_id      = '0;
    logic [7:0]  body_len    = '0;
    logic [7:0]  data_byte   = '0;
    logic        out_ready   = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        rejected;

    int          errors;
    int          pending;
    int          frames;
    int          rejects;
    int          bytes;
    int          items_in;
    int          cycles;
    logic        tx_burst    = 1'b0;
    logic        rx_burst    = 1'b0;
    int          rx_hold     = 0;
    int          rx_draw;

    obfuscated_frame_builder_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_operation (operation),
        .i_cmd_id    (cmd_id),
        .i_body_len  (body_len),
        .i_data_byte (data_byte),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_byte  (out_byte),
        .o_frame_end (frame_end),
        .o_rejected  (rejected)
    );

    ofb_frame_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_operation (operation),
        .i_cmd_id    (cmd_id),
        .i_body_len  (body_len),
        .i_data_byte (data_byte),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_byte  (out_byte),
        .i_frame_end (frame_end),
        .i_rejected  (rejected),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_frames    (frames),
        .o_rejects   (rejects),
        .o_bytes     (bytes)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // output side: a random hold-off (possibly none) after each transfer, none in burst stretches
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) rx_burst <= ~rx_burst;
            if (out_ready && out_valid) begin
                rx_draw = rx_burst ? 0 : $urandom_range(0, 16);
                if (rx_draw != 0) begin
                    out_ready <= 1'b0;
                    rx_hold   <= rx_draw;
                end
            end else if (!out_ready) begin
                if (rx_hold <= 1) begin
                    out_ready <= 1'b1;
                end else begin
                    rx_hold <= rx_hold - 1;
                end
            end
        end
    end

    task automatic send(input logic op, input logic [15:0] id, input logic [7:0] len,
                        input logic [7:0] db);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        cmd_id    <= id;
        body_len  <= len;
        data_byte <= db;
        do @(posedge clk); while (!in_ready);
        items_in++;
    endtask

    task automatic start_frame(input logic [15:0] id, input logic [7:0] len);
        send(OP_START, id, len, 8'($urandom));
    endtask

    task automatic data_item(input logic [7:0] db);
        send(OP_DATA, 16'($urandom), 8'($urandom), db);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int budget;
        int sel;
        int len;
        int body;
        budget = 0;
        items_in = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        data_item(8'h5A);
        start_frame(16'h0000, 8'd0);
        start_frame(16'hFFFF, 8'd0);
        start_frame(16'h1234, 8'(MAX_DATA + 1));
        start_frame(16'h0000, 8'hFF);
        start_frame(16'hA5C3, 8'd1);
        data_item(8'hFF);
        start_frame(16'h00FF, 8'd2);
        data_item(8'h00);
        data_item(8'h80);
        start_frame(16'h4321, 8'd5);
        data_item(8'h11);
        data_item(8'h22);
        start_frame(16'hFF00, 8'd3);
        data_item(8'h01);
        start_frame(16'h0F0F, 8'd250);
        data_item(8'h33);
        start_frame(16'h8001, 8'd1);
        data_item(8'h7F);

        // hold the input until the output has caught up
        in_valid <= 1'b0;
        wait_drained();

        // largest accepted length, cut short by the next start
        tx_burst = 1'b1;
        start_frame(16'($urandom), 8'(MAX_DATA));
        for (int i = 0; i < CUT_LEN; i++) begin
            data_item(8'($urandom));
        end

        // a frame long enough to wrap the key several times
        start_frame(16'($urandom), 8'(LONG_LEN));
        for (int i = 0; i < LONG_LEN; i++) begin
            if (i == LONG_LEN / 2) tx_burst = 1'b0;
            data_item(8'($urandom));
        end

        // random frames
        while (budget < RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                len = $urandom_range(MAX_DATA + 1, 255);
            end else if (sel < 12) begin
                len = 0;
            end else if (sel < 18) begin
                len = $urandom_range(25, 60);
            end else begin
                len = $urandom_range(1, 24);
            end
            start_frame(16'($urandom), 8'(len));
            budget++;
            body = (len > MAX_DATA) ? 0 : len;
            if (body > 0 && $urandom_range(0, 7) == 0) begin
                body = $urandom_range(0, body - 1);
            end
            for (int i = 0; i < body; i++) begin
                data_item(8'($urandom));
                budget++;
            end
            if ((body == len || len > MAX_DATA) && $urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) data_item(8'($urandom));
            end
            if ($urandom_range(0, 9) == 0) begin
                in_valid <= 1'b0;
                wait_drained();
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input transfers: %0d frames closed, %0d starts rejected,",
                 items_in, frames, rejects);
        $display("%0d output bytes checked against the predicted stream.", bytes);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
    end

endmodule
